/* rtl/bankers_safety_check_assert.svh */
// Assertion macros for the banker's safety check block.
// Uses i_clk and i_rst_n of the including module; no other dependencies.
`ifndef BANKERS_SAFETY_CHECK_ASSERT_SVH
`define BANKERS_SAFETY_CHECK_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define BSC_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define BSC_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bsc_pkg.sv */
// Shared constants and types for the banker's safety check block.
// No dependencies.
package bsc_pkg;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 4;
    localparam int AMOUNT_W  = 16;
    localparam int AVAIL_W   = 20;
    localparam int ID_W      = 4;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_MAX   = 2'd1;
    localparam logic [OP_W-1:0] OP_AVAIL = 2'd2;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 1'd1;

    localparam logic [AVAIL_W-1:0] AVAIL_MAX = '1;

    // write strobes and read enable for the allocation / maximum store
    typedef struct packed {
        logic alloc_we;
        logic max_we;
        logic rd_en;
    } t_mat_ctl;

endpackage

/* rtl/bsc_if.sv */
// Valid/ready channel interfaces for load/run items and results.
// Depends on bsc_pkg for field widths.
interface bsc_in_if;
    logic                          valid;
    logic                          ready;
    logic [bsc_pkg::OP_W-1:0]      op;
    logic [bsc_pkg::IDX_W-1:0]     proc_index;
    logic [bsc_pkg::IDX_W-1:0]     res_index;
    logic [bsc_pkg::AMOUNT_W-1:0]  amount;

    modport source(output valid, op, proc_index, res_index, amount, input ready);
    modport sink(input valid, op, proc_index, res_index, amount, output ready);
endinterface

interface bsc_out_if;
    logic                      valid;
    logic                      ready;
    logic [bsc_pkg::ID_W-1:0]  proc_id;
    logic                      has_proc;
    logic                      is_safe;
    logic                      last;

    modport source(output valid, proc_id, has_proc, is_safe, last, input ready);
    modport sink(input valid, proc_id, has_proc, is_safe, last, output ready);
endinterface

/* rtl/bsc_matrix.sv */
// Allocation and maximum matrices: two single-port-write RAMs, registered read.
// Depends on bsc_pkg (t_mat_ctl, AMOUNT_W).
module bsc_matrix #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                          i_clk,
    input  bsc_pkg::t_mat_ctl             i_ctl,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [bsc_pkg::AMOUNT_W-1:0]  i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [bsc_pkg::AMOUNT_W-1:0]  o_alloc_q,
    output logic [bsc_pkg::AMOUNT_W-1:0]  o_max_q
);

    logic [bsc_pkg::AMOUNT_W-1:0] alloc_mem [DEPTH];
    logic [bsc_pkg::AMOUNT_W-1:0] max_mem   [DEPTH];
    logic [bsc_pkg::AMOUNT_W-1:0] r_alloc_q;
    logic [bsc_pkg::AMOUNT_W-1:0] r_max_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.alloc_we) begin
            alloc_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_alloc_q <= alloc_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.max_we) begin
            max_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_max_q <= max_mem[i_raddr];
        end
    end

    assign o_alloc_q = r_alloc_q;
    assign o_max_q   = r_max_q;

endmodule

/* rtl/bankers_safety_check.sv */
// Banker's algorithm safety check: load matrices, run sweeps, stream the safe order.
// Depends on bsc_pkg, bsc_if (bsc_in_if, bsc_out_if), bsc_matrix and the assert header.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-----------------------------------------
//  i_in     | in  | valid / ready   | op, proc_index, res_index, amount
//  o_out    | out | valid / ready   | proc_id, has_proc, is_safe, last
//  i_cfg_*  | in  | write enable    | i_cfg_idx, i_cfg_data (no back-pressure)
//
// Load items are taken back to back while idle.
// A run holds i_in.ready low; each process tested gets a need check and, when it
// fits, a release (one memory read per cycle for each).
// Each safe-order result passes through an order store read, then the output register.
// Synchronous active-low reset clears control state only; the stores are undefined.
// A stalled o_out holds the result; loads may still be accepted behind it.
`include "bankers_safety_check_assert.svh"

module bankers_safety_check #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bsc_pkg::COUNT_W-1:0]     i_cfg_data,
    bsc_in_if.sink                          i_in,
    bsc_out_if.source                       o_out
);

    localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCW   = $clog2(MAX_PROCESSES + 1);
    localparam int RCW   = $clog2(MAX_RESOURCES + 1);
    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDW   = bsc_pkg::ID_W;
    localparam int AVW   = bsc_pkg::AVAIL_W;
    localparam int AMW   = bsc_pkg::AMOUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_FIT,
        S_REL,
        S_EMIT_RD,
        S_EMIT_WR,
        S_EMIT_ONE
    } t_state;

    t_state                      r_state;
    logic [bsc_pkg::COUNT_W-1:0] r_proc_cnt;
    logic [bsc_pkg::COUNT_W-1:0] r_res_cnt;
    logic [PCW-1:0]              r_np;
    logic [RCW-1:0]              r_nr;
    logic [PCW-1:0]              r_p;        // process under test
    logic [RCW-1:0]              r_r;        // resource read pointer
    logic                        r_pend;     // memory data arrives this cycle
    logic [RW-1:0]               r_pend_r;
    logic                        r_ok;
    logic                        r_progress;
    logic [PCW-1:0]              r_done;
    logic [MAX_PROCESSES-1:0]    r_fin;
    logic [PCW-1:0]              r_k;        // emit position
    logic                        r_one_safe;
    logic [IDW-1:0]              r_ord_q;
    logic [AVW-1:0]              r_avail_q;

    logic                        r_out_valid;
    logic [IDW-1:0]              r_out_id;
    logic                        r_out_has;
    logic                        r_out_safe;
    logic                        r_out_last;

    logic [AVW-1:0]              avail_mem [MAX_RESOURCES];
    logic [IDW-1:0]              ord_mem   [MAX_PROCESSES];

    logic                        ld_acc;
    logic                        is_run;
    logic                        ld_p_ok;
    logic                        ld_r_ok;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic [PW-1:0]               p_idx;
    logic [RW-1:0]               r_idx;
    logic                        issue;
    bsc_pkg::t_mat_ctl           mat_ctl;
    logic [AMW-1:0]              alloc_q;
    logic [AMW-1:0]              max_q;
    logic                        fit_fail;
    logic [AVW:0]                rel_sum;
    logic [AVW-1:0]              rel_sat;
    logic                        av_we;
    logic [RW-1:0]               av_waddr;
    logic [AVW-1:0]              av_wdata;
    logic                        ord_we;
    logic                        out_free;
    logic                        out_load;
    logic                        last_k;
    logic [PCW-1:0]              n_np;
    logic [RCW-1:0]              n_nr;

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    assign i_in.ready = (r_state == S_IDLE);
    assign ld_acc     = i_in.valid && i_in.ready;
    assign is_run     = (i_in.op == bsc_pkg::OP_RUN);
    assign ld_p_ok    = (32'(i_in.proc_index) < MAX_PROCESSES);
    assign ld_r_ok    = (32'(i_in.res_index) < MAX_RESOURCES);
    assign wr_addr    = AW'(32'(i_in.proc_index) * MAX_RESOURCES + 32'(i_in.res_index));

    // counts above the build limits fall back to the limit
    assign n_np = (32'(r_proc_cnt) > MAX_PROCESSES) ? PCW'(MAX_PROCESSES) : PCW'(r_proc_cnt);
    assign n_nr = (32'(r_res_cnt) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES) : RCW'(r_res_cnt);

    // ---------------------------------------------------------------
    // Matrix walk: one read per cycle, data registered and used in the next cycle, no later
    // ---------------------------------------------------------------
    assign p_idx   = r_p[PW-1:0];
    assign r_idx   = r_r[RW-1:0];
    assign issue   = ((r_state == S_FIT) || (r_state == S_REL)) && (r_r < r_nr);
    assign rd_addr = AW'(32'(p_idx) * MAX_RESOURCES + 32'(r_idx));

    always_comb begin
        mat_ctl.alloc_we = ld_acc && (i_in.op == bsc_pkg::OP_ALLOC) && ld_p_ok && ld_r_ok;
        mat_ctl.max_we   = ld_acc && (i_in.op == bsc_pkg::OP_MAX) && ld_p_ok && ld_r_ok;
        mat_ctl.rd_en    = issue;
    end

    bsc_matrix #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_matrix (
        .i_clk     (i_clk),
        .i_ctl     (mat_ctl),
        .i_waddr   (wr_addr),
        .i_wdata   (i_in.amount),
        .i_raddr   (rd_addr),
        .o_alloc_q (alloc_q),
        .o_max_q   (max_q)
    );

    // need = max - alloc; a negative need always fits
    assign fit_fail = (max_q > alloc_q) && (AVW'(max_q - alloc_q) > r_avail_q);

    // release: available += allocation, saturating
    assign rel_sum = {1'b0, r_avail_q} + (AVW + 1)'(alloc_q);
    assign rel_sat = rel_sum[AVW] ? bsc_pkg::AVAIL_MAX : rel_sum[AVW-1:0];

    // ---------------------------------------------------------------
    // Available vector: load writes while idle, read-modify-write in release.
    // Release writes entry r while reading entry r+1, so no overlap.
    // ---------------------------------------------------------------
    always_comb begin
        if (r_state == S_REL) begin
            av_we    = r_pend;
            av_waddr = r_pend_r;
            av_wdata = rel_sat;
        end else begin
            av_we    = ld_acc && (i_in.op == bsc_pkg::OP_AVAIL) && ld_r_ok;
            av_waddr = RW'(i_in.res_index);
            av_wdata = AVW'(i_in.amount);
        end
    end

    always_ff @(posedge i_clk) begin
        if (av_we) begin
            avail_mem[av_waddr] <= av_wdata;
        end
        if (issue) begin
            r_avail_q <= avail_mem[r_idx];
        end
    end

    // ---------------------------------------------------------------
    // Safe-order store: written when a process finishes, read on emit
    // ---------------------------------------------------------------
    assign ord_we = (r_state == S_REL) && !issue && !r_pend;

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            ord_mem[r_done[PW-1:0]] <= IDW'(p_idx);
        end
        if (r_state == S_EMIT_RD) begin
            r_ord_q <= ord_mem[r_k[PW-1:0]];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer and output register
    // ---------------------------------------------------------------
    assign out_free = !r_out_valid || o_out.ready;
    assign out_load = ((r_state == S_EMIT_WR) || (r_state == S_EMIT_ONE)) && out_free;
    assign last_k   = (r_k == r_np - PCW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_proc_cnt  <= '0;
            r_res_cnt   <= '0;
            r_fin       <= '0;
            r_done      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bsc_pkg::CFG_PROCESS_COUNT:  r_proc_cnt <= i_cfg_data;
                    bsc_pkg::CFG_RESOURCE_COUNT: r_res_cnt  <= i_cfg_data;
                    default: ;
                endcase
            end

            // a new result replaces one leaving on this edge
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            r_pend <= issue;
            if (issue) begin
                r_pend_r <= r_idx;
                r_r      <= r_r + RCW'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (ld_acc && is_run) begin
                        r_np       <= n_np;
                        r_nr       <= n_nr;
                        r_fin      <= '0;
                        r_done     <= '0;
                        r_p        <= '0;
                        r_progress <= 1'b0;
                        if (n_np == '0) begin
                            r_one_safe <= 1'b1;
                            r_state    <= S_EMIT_ONE;
                        end else begin
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    if (r_p == r_np) begin
                        if (r_done == r_np) begin
                            r_k     <= '0;
                            r_state <= S_EMIT_RD;
                        end else if (!r_progress) begin
                            r_one_safe <= 1'b0;
                            r_state    <= S_EMIT_ONE;
                        end else begin
                            r_p        <= '0;
                            r_progress <= 1'b0;
                        end
                    end else if (r_fin[p_idx]) begin
                        r_p <= r_p + PCW'(1);
                    end else begin
                        r_r     <= '0;
                        r_ok    <= 1'b1;
                        r_state <= S_FIT;
                    end
                end
                S_FIT: begin
                    if (r_pend && fit_fail) begin
                        r_ok <= 1'b0;
                    end
                    if (!issue && !r_pend) begin
                        if (r_ok) begin
                            r_r     <= '0;
                            r_state <= S_REL;
                        end else begin
                            r_p     <= r_p + PCW'(1);
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_REL: begin
                    if (!issue && !r_pend) begin
                        r_fin[p_idx] <= 1'b1;
                        r_done       <= r_done + PCW'(1);
                        r_progress   <= 1'b1;
                        r_p          <= r_p + PCW'(1);
                        r_state      <= S_SWEEP;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_WR;
                end
                S_EMIT_WR: begin
                    if (out_free) begin
                        r_out_id    <= r_ord_q;
                        r_out_has   <= 1'b1;
                        r_out_safe  <= 1'b1;
                        r_out_last  <= last_k;
                        if (last_k) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + PCW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_EMIT_ONE: begin
                    if (out_free) begin
                        r_out_id    <= '0;
                        r_out_has   <= 1'b0;
                        r_out_safe  <= r_one_safe;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.proc_id  = r_out_id;
    assign o_out.has_proc = r_out_has;
    assign o_out.is_safe  = r_out_safe;
    assign o_out.last     = r_out_last;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `BSC_CHECK(a_fin_count, $countones(r_fin) == int'(r_done), "finished flags vs count")
    `BSC_CHECK(a_rel_unfinished, (r_state != S_REL) || !r_fin[p_idx], "release of finished process")
    `BSC_CHECK(a_emit_all_done, (r_state != S_EMIT_RD) || (r_done == r_np), "safe order emitted early")
    `BSC_CHECK(a_out_src, !$rose(r_out_valid) || $past(out_load), "result outside emit")
    `BSC_CHECK_NEXT(a_last_idle, (r_state == S_EMIT_WR) && out_free && last_k, (r_state == S_IDLE) && r_out_last, "last result did not end run")

endmodule

/* tb/sv/bankers_safety_check_tb.sv */
// Self-checking testbench for bankers_safety_check: loads the matrices, runs checks and
// compares each streamed result with a cycle-free predictor of the safe order.
// Depends on bsc_pkg, bsc_if (bsc_in_if, bsc_out_if) and the bankers_safety_check RTL.
module bankers_safety_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC           = 16;
    localparam int NRES            = 16;
    localparam int SETTLE_CYCLES   = 8;      // generous margin for the block to settle
    localparam int END_PAD_CYCLES  = 50;
    localparam int WATCHDOG_CYCLES = 20000;  // limit on cycles with no transfer or register write
    localparam int SEGMENT_ITEMS   = 38;     // three segments; ~170 items with the directed tests

    // one result of a run, in port order
    typedef struct packed {
        logic [bsc_pkg::ID_W-1:0] proc_id;
        logic                     has_proc;
        logic                     is_safe;
        logic                     last;
    } t_verdict;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [bsc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bsc_pkg::COUNT_W-1:0]   i_cfg_data;

    bsc_in_if  in_ch ();
    bsc_out_if out_ch ();

    bankers_safety_check #(
        .MAX_PROCESSES (NPROC),
        .MAX_RESOURCES (NRES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // ---------------------------------------------------------------------
    // Predictor state: a shadow of the block's stores and count registers
    // ---------------------------------------------------------------------
    logic [bsc_pkg::AMOUNT_W-1:0] alloc_mx [NPROC][NRES];
    logic [bsc_pkg::AMOUNT_W-1:0] claim_mx [NPROC][NRES];
    logic [bsc_pkg::AVAIL_W-1:0]  avail_vec [NRES];
    logic [bsc_pkg::COUNT_W-1:0]  proc_cnt;
    logic [bsc_pkg::COUNT_W-1:0]  res_cnt;

    // Which entries the stimulus has written; a run never reads one still unset.
    bit alloc_known [NPROC][NRES];
    bit claim_known [NPROC][NRES];
    bit avail_known [NRES];

    t_verdict verdict_q [$];   // results still owed by the block, oldest first

    int fail_count  = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    int tx_gap_pct  = 0;      // chance in 100 that the sender idles a cycle
    int rx_stall_pct = 0;     // chance in 100 that the receiver stalls a cycle

    // ---------------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Counts above the store size behave as the store size.
    function automatic int procs_in_use();
        return (proc_cnt > NPROC) ? NPROC : int'(proc_cnt);
    endfunction

    function automatic int res_in_use();
        return (res_cnt > NRES) ? NRES : int'(res_cnt);
    endfunction

    // ---------------------------------------------------------------------
    // Safe-order predictor. Sweeps the unfinished processes in index order;
    // a process that fits releases its allocation straight away, so a later
    // process in the same sweep already sees the larger available vector.
    // ---------------------------------------------------------------------
    function automatic void predict_safe_order();
        int                       np_eff;
        int                       nr_eff;
        int                       done;
        int                       p;
        int                       r;
        int                       need;
        int                       room;
        int unsigned              total;
        bit [NPROC-1:0]           finished;
        bit                       progress;
        bit                       fits;
        logic [bsc_pkg::ID_W-1:0] order [NPROC];

        np_eff   = procs_in_use();
        nr_eff   = res_in_use();
        finished = '0;
        done     = 0;

        while (done < np_eff) begin
            progress = 1'b0;
            for (p = 0; p < np_eff; p++) begin
                if (!finished[p]) begin
                    fits = 1'b1;
                    for (r = 0; r < nr_eff; r++) begin
                        need = claim_mx[p][r];
                        need = need - alloc_mx[p][r];   // may go negative
                        room = avail_vec[r];
                        if (need > room)
                            fits = 1'b0;
                    end
                    if (fits) begin
                        // release, saturating at the top of the 20-bit range
                        for (r = 0; r < nr_eff; r++) begin
                            total = avail_vec[r];
                            total = total + alloc_mx[p][r];
                            avail_vec[r] = (total > bsc_pkg::AVAIL_MAX) ?
                                           bsc_pkg::AVAIL_MAX : total[bsc_pkg::AVAIL_W-1:0];
                        end
                        order[done] = p[bsc_pkg::ID_W-1:0];
                        done++;
                        finished[p] = 1'b1;
                        progress    = 1'b1;
                    end
                end
            end
            if (!progress)
                break;
        end

        if (np_eff == 0) begin
            // nothing to schedule counts as safe, with no process attached
            verdict_q.push_back(t_verdict'{'0, 1'b0, 1'b1, 1'b1});
        end else if (done < np_eff) begin
            verdict_q.push_back(t_verdict'{'0, 1'b0, 1'b0, 1'b1});
        end else begin
            for (p = 0; p < np_eff; p++)
                verdict_q.push_back(t_verdict'{order[p], 1'b1, 1'b1, p == np_eff - 1});
        end
    endfunction

    // ---------------------------------------------------------------------
    // Input monitor: every load transfer on the item channel updates the shadow
    // stores, and a run item queues the results it must produce.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            case (in_ch.op)
                bsc_pkg::OP_ALLOC:
                    alloc_mx[in_ch.proc_index][in_ch.res_index] = in_ch.amount;
                bsc_pkg::OP_MAX:
                    claim_mx[in_ch.proc_index][in_ch.res_index] = in_ch.amount;
                bsc_pkg::OP_AVAIL:
                    avail_vec[in_ch.res_index] =
                        {{(bsc_pkg::AVAIL_W-bsc_pkg::AMOUNT_W){1'b0}}, in_ch.amount};
                bsc_pkg::OP_RUN:
                    predict_safe_order();
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Result checker: each result transfer against the oldest expectation
    // ---------------------------------------------------------------------
    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = t_verdict'{out_ch.proc_id, out_ch.has_proc, out_ch.is_safe, out_ch.last};
            if (verdict_q.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %p",
                         $time, got);
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                check_field("proc_id",  want.proc_id,  got.proc_id);
                check_field("has_proc", want.has_proc, got.has_proc);
                check_field("is_safe",  want.is_safe,  got.is_safe);
                check_field("last",     want.last,     got.last);
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle; low while in reset.
    always @(posedge i_clk)
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= rx_stall_pct);

    // Watchdog: any transfer or register write counts as activity.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("bankers_safety_check: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Sends one item and returns at the edge of its transfer. Valid is left
    // high so a following item goes out back to back; whoever stops sending
    // lowers it.
    task automatic send_cmd(input logic [bsc_pkg::OP_W-1:0] op,
                            input logic [bsc_pkg::IDX_W-1:0] pi,
                            input logic [bsc_pkg::IDX_W-1:0] ri,
                            input logic [bsc_pkg::AMOUNT_W-1:0] amt);
        while ($urandom_range(99) < tx_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.proc_index <= pi;
        in_ch.res_index  <= ri;
        in_ch.amount     <= amt;
        case (op)
            bsc_pkg::OP_ALLOC: alloc_known[pi][ri] = 1'b1;
            bsc_pkg::OP_MAX:   claim_known[pi][ri] = 1'b1;
            bsc_pkg::OP_AVAIL: avail_known[ri]     = 1'b1;
            default: ;
        endcase
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Stops sending, waits for every owed result, then lets the block settle.
    // The first edge lets the monitor queue the results of a run just sent.
    task automatic drain_results(input int pad);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (pad) @(posedge i_clk);
    endtask

    // Writes both count registers, the process count first; only call when idle.
    task automatic set_counts(input logic [bsc_pkg::COUNT_W-1:0] np,
                              input logic [bsc_pkg::COUNT_W-1:0] nr);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bsc_pkg::CFG_PROCESS_COUNT;
        i_cfg_data <= np;
        @(posedge i_clk);
        proc_cnt    = np;
        i_cfg_idx  <= bsc_pkg::CFG_RESOURCE_COUNT;
        i_cfg_data <= nr;
        @(posedge i_clk);
        res_cnt     = nr;
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly small amounts, so that runs come out safe often enough, plus
    // the extremes and the odd full-range value.
    function automatic logic [bsc_pkg::AMOUNT_W-1:0] pick_amount();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return bsc_pkg::AMOUNT_W'($urandom_range(16'hFFFF));
            default: return bsc_pkg::AMOUNT_W'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [bsc_pkg::IDX_W-1:0] pick_index(input int span);
        if (span == 0 || $urandom_range(4) == 0)
            return bsc_pkg::IDX_W'($urandom_range(15));
        return bsc_pkg::IDX_W'($urandom_range(span - 1));
    endfunction

    // Writes every entry of the region in use that has never been written.
    task automatic load_missing_entries();
        int p;
        int r;
        for (p = 0; p < procs_in_use(); p++) begin
            for (r = 0; r < res_in_use(); r++) begin
                if (!alloc_known[p][r])
                    send_cmd(bsc_pkg::OP_ALLOC, p[bsc_pkg::IDX_W-1:0],
                             r[bsc_pkg::IDX_W-1:0], pick_amount());
                if (!claim_known[p][r])
                    send_cmd(bsc_pkg::OP_MAX, p[bsc_pkg::IDX_W-1:0],
                             r[bsc_pkg::IDX_W-1:0], pick_amount());
            end
        end
        for (r = 0; r < res_in_use(); r++)
            if (!avail_known[r])
                send_cmd(bsc_pkg::OP_AVAIL, bsc_pkg::IDX_W'($urandom_range(15)),
                         r[bsc_pkg::IDX_W-1:0], pick_amount());
    endtask

    task automatic send_run();
        send_cmd(bsc_pkg::OP_RUN, bsc_pkg::IDX_W'($urandom_range(15)),
                 bsc_pkg::IDX_W'($urandom_range(15)),
                 bsc_pkg::AMOUNT_W'($urandom_range(16'hFFFF)));
    endtask

    // ---------------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------------

    // No processes: a single safe result without a process id.
    task automatic test_empty_set();
        drain_results(SETTLE_CYCLES);
        set_counts(5'd0, 5'd0);
        send_cmd(bsc_pkg::OP_RUN, 4'hF, 4'hF, 16'hFFFF);
    endtask

    // No resources: every process fits on the first sweep, in index order.
    task automatic test_no_resources();
        drain_results(SETTLE_CYCLES);
        set_counts(5'd3, 5'd0);
        send_run();
    endtask

    // Oversized process count (acts as 16), full allocations and negative
    // needs: all sixteen release and available saturates.
    task automatic test_saturation();
        int p;
        drain_results(SETTLE_CYCLES);
        set_counts(5'd31, 5'd1);
        for (p = 0; p < NPROC; p++) begin
            send_cmd(bsc_pkg::OP_ALLOC, p[bsc_pkg::IDX_W-1:0], 4'd0, 16'hFFFF);
            send_cmd(bsc_pkg::OP_MAX,   p[bsc_pkg::IDX_W-1:0], 4'd0, 16'h0000);
        end
        send_cmd(bsc_pkg::OP_AVAIL, 4'd0, 4'd0, 16'hFFFF);
        send_run();
    endtask

    // Second resource can never be met: one unsafe result.
    task automatic test_unsafe();
        int p;
        drain_results(SETTLE_CYCLES);
        set_counts(5'd2, 5'd2);
        for (p = 0; p < 2; p++) begin
            send_cmd(bsc_pkg::OP_ALLOC, p[bsc_pkg::IDX_W-1:0], 4'd1, 16'h0000);
            send_cmd(bsc_pkg::OP_MAX,   p[bsc_pkg::IDX_W-1:0], 4'd1, 16'hFFFF);
        end
        send_cmd(bsc_pkg::OP_AVAIL, 4'd0, 4'd1, 16'h0000);
        send_run();
    endtask

    // Process 0 only fits after 1 and 2 release, giving order 1, 2, 0.
    // A second run without reloading sees the grown available: 0, 1, 2.
    task automatic test_late_finisher();
        drain_results(SETTLE_CYCLES);
        set_counts(5'd3, 5'd1);
        send_cmd(bsc_pkg::OP_ALLOC, 4'd0, 4'd0, 16'd0);
        send_cmd(bsc_pkg::OP_MAX,   4'd0, 4'd0, 16'd5);
        send_cmd(bsc_pkg::OP_ALLOC, 4'd1, 4'd0, 16'd4);
        send_cmd(bsc_pkg::OP_MAX,   4'd1, 4'd0, 16'd5);
        send_cmd(bsc_pkg::OP_ALLOC, 4'd2, 4'd0, 16'd0);
        send_cmd(bsc_pkg::OP_MAX,   4'd2, 4'd0, 16'd2);
        send_cmd(bsc_pkg::OP_AVAIL, 4'd0, 4'd0, 16'd1);
        send_run();
        send_run();
    endtask

    // ---------------------------------------------------------------------
    // Random traffic: rounds of optional recount, a few loads aimed mostly at
    // the region in use, any missing entries, then one or two runs.
    // ---------------------------------------------------------------------
    task automatic random_round();
        int np;
        int nr;
        int n;
        if ($urandom_range(2) == 0) begin
            case ($urandom_range(9))
                0: begin np = 0;                      nr = $urandom_range(31);    end
                1: begin np = $urandom_range(16, 31); nr = $urandom_range(1);     end
                2: begin np = $urandom_range(1, 2);   nr = $urandom_range(16, 31); end
                default: begin np = $urandom_range(1, 5); nr = $urandom_range(4); end
            endcase
            drain_results(SETTLE_CYCLES);
            set_counts(np[bsc_pkg::COUNT_W-1:0], nr[bsc_pkg::COUNT_W-1:0]);
        end
        n = $urandom_range(6);
        repeat (n)
            send_cmd(bsc_pkg::OP_W'($urandom_range(2)), pick_index(procs_in_use()),
                     pick_index(res_in_use()), pick_amount());
        load_missing_entries();
        send_run();
        if ($urandom_range(3) == 0)
            send_run();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int quota);
        int start;
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        start        = items_sent;
        while (items_sent - start < quota)
            random_round();
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = bsc_pkg::CFG_PROCESS_COUNT;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.op         = bsc_pkg::OP_ALLOC;
        in_ch.proc_index = '0;
        in_ch.res_index  = '0;
        in_ch.amount     = '0;
        proc_cnt         = '0;
        res_cnt          = '0;
        tx_gap_pct       = 14;
        rx_stall_pct     = 88;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_set();
        test_no_resources();
        test_saturation();
        test_unsafe();
        test_late_finisher();

        test_random_traffic(14, 88, SEGMENT_ITEMS);
        test_random_traffic(88, 14, SEGMENT_ITEMS);
        test_random_traffic(0, 0, SEGMENT_ITEMS);

        drain_results(END_PAD_CYCLES);
        if (fail_count == 0 && verdict_q.size() == 0)
            $display("bankers_safety_check: match");
        else
            $display("bankers_safety_check: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bsc_pkg.sv
rtl/bsc_if.sv
rtl/bsc_matrix.sv
rtl/bankers_safety_check.sv
tb/sv/bankers_safety_check_tb.sv
